[rtl/assert_macros.svh]
// Assertion macros for the checker file of the text terminal writer.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ttw_pkg.sv]
// Shared types and constants for the text terminal writer.
// No dependencies; imported by the top level, ttw_cursor and ttw_checker.
`timescale 1ns / 1ps

package ttw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int TAB_STEP    = 8;

  localparam logic [15:0] BLANK_CELL  = 16'h0720;
  localparam logic [7:0]  COLOR_RESET = 8'h07;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    REQ_PUTC  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_PUTAT = 2'd3
  } req_e;

  // Cursor commands from the request decoder.
  typedef struct packed {
    logic put_char;
    logic clear;
  } ttw_cmd_t;

endpackage

[rtl/text_terminal_writer_top.sv]
// Text terminal writer: cell RAM, cursor and request sequencer.
// Depends on ttw_pkg, ttw_ram and ttw_cursor.
`timescale 1ns / 1ps

// A request is taken on a clock edge with start_i high and busy_o low. While
// busy_o is low, a new put-char, put-at or read request can be issued every
// cycle; the result appears on the cycle after the request with done_o high for
// that one cycle and must be captured then, the receiver cannot hold it off.
// Read data comes straight from the registered output of the cell RAM. Clear
// and the pass that follows reset rewrite all COLUMNS*ROWS cells (2000 by
// default) through the single RAM write port, one cell a cycle, busy_o high.
// Clear reports its result on the cycle after the pass ends; the pass after
// reset reports nothing. The cursor ports always show the cursor after the
// last request. text_color is written through cfg_valid_i / cfg_data_i, always
// ready; the user must write it only while the block is idle (not enforced).

module text_terminal_writer_top import ttw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  cell_color_i,
  input  logic [6:0]  pos_x_i,
  input  logic [4:0]  pos_y_i,
  output logic        done_o,
  output logic        cell_written_o,
  output logic [10:0] cell_address_o,
  output logic [15:0] cell_data_o,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          clr_req_q, clr_req_d;
  logic [7:0]    color_q;

  logic          res_valid_q, res_valid_d;
  logic          rd_sel_q, rd_sel_d;
  logic          res_wr_q, res_wr_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic [15:0]   res_data_q, res_data_d;

  logic          acc;
  req_e          req;
  logic          in_range;
  logic [AW-1:0] pos_idx, cur_idx;
  ttw_cmd_t      cmd;
  logic          print;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata, mem_rdata;

  assign req      = req_e'(req_type_i);
  assign acc      = start_i && (state_q == ST_IDLE);
  assign in_range = (32'(pos_x_i) < 32'(COLUMNS)) && (32'(pos_y_i) < 32'(ROWS));
  assign pos_idx  = AW'(32'(pos_y_i) * 32'(COLUMNS) + 32'(pos_x_i));
  assign cur_idx  = AW'(32'(cur_row) * 32'(COLUMNS) + 32'(cur_col));

  assign cmd.put_char = acc && (req == REQ_PUTC);
  assign cmd.clear    = acc && (req == REQ_CLEAR);

  ttw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .char_i  (char_code_i),
    .print_o (print),
    .col_o   (cur_col),
    .row_o   (cur_row)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_req_d   = clr_req_q;
    res_valid_d = 1'b0;
    rd_sel_d    = rd_sel_q;
    res_wr_d    = res_wr_q;
    res_addr_d  = res_addr_q;
    res_data_d  = res_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = pos_idx;
    mem_wdata   = {cell_color_i, char_code_i};

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          res_valid_d = 1'b1;
          rd_sel_d    = 1'b0;
          res_wr_d    = 1'b0;
          res_addr_d  = '0;
          res_data_d  = '0;
          case (req)
            REQ_PUTC: begin
              if (print) begin
                mem_we     = 1'b1;
                mem_waddr  = cur_idx;
                mem_wdata  = {color_q, char_code_i};
                res_wr_d   = 1'b1;
                res_addr_d = cur_idx;
                res_data_d = {color_q, char_code_i};
              end
            end
            REQ_CLEAR: begin
              // result follows the end of the sweep
              res_valid_d = 1'b0;
              clr_req_d   = 1'b1;
              cnt_d       = '0;
              state_d     = ST_SWEEP;
            end
            REQ_READ: begin
              if (in_range) begin
                mem_re     = 1'b1;
                rd_sel_d   = 1'b1;
                res_addr_d = pos_idx;
              end
            end
            REQ_PUTAT: begin
              if (in_range) begin
                mem_we     = 1'b1;
                res_wr_d   = 1'b1;
                res_addr_d = pos_idx;
                res_data_d = {cell_color_i, char_code_i};
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = BLANK_CELL;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d     = ST_IDLE;
          cnt_d       = '0;
          clr_req_d   = 1'b0;
          res_valid_d = clr_req_q;
          rd_sel_d    = 1'b0;
          res_wr_d    = 1'b0;
          res_addr_d  = '0;
          res_data_d  = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ttw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_idx),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      cnt_q       <= '0;
      clr_req_q   <= 1'b0;
      res_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
      color_q     <= COLOR_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_req_q   <= clr_req_d;
      res_valid_q <= res_valid_d;
      rd_sel_q    <= rd_sel_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_wr_q   <= res_wr_d;
    res_addr_q <= res_addr_d;
    res_data_q <= res_data_d;
  end

  assign busy_o          = (state_q == ST_SWEEP);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = res_valid_q;
  assign cell_written_o  = res_wr_q;
  assign cell_address_o  = 11'(res_addr_q);
  assign cell_data_o     = rd_sel_q ? mem_rdata : res_data_q;
  assign cursor_column_o = 7'(cur_col);
  assign cursor_row_o    = 5'(cur_row);

endmodule

[rtl/ttw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ttw_cursor.sv]
// Cursor registers and put-char control decode of the text terminal writer.
// Depends on ttw_pkg.
`timescale 1ns / 1ps

module ttw_cursor import ttw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ttw_cmd_t      cmd_i,
  input  logic [7:0]    char_i,
  output logic          print_o,
  output logic [CW-1:0] col_o,
  output logic [RW-1:0] row_o
);

  localparam logic [CW:0] TAB_ADD  = (CW+1)'(TAB_STEP);
  localparam logic [CW:0] TAB_MASK = ~((CW+1)'(TAB_STEP - 1));
  localparam logic [CW:0] COL_END  = (CW+1)'(COLUMNS);
  localparam logic [RW:0] ROW_END  = (RW+1)'(ROWS);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_inc, col_tab;
  logic [RW:0]   row_inc;
  logic          line_feed;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    print_o   = 1'b0;
    line_feed = 1'b0;
    col_inc   = {1'b0, col_q} + 1'b1;
    col_tab   = ({1'b0, col_q} + TAB_ADD) & TAB_MASK;
    row_inc   = {1'b0, row_q} + 1'b1;

    if (cmd_i.clear) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.put_char) begin
      case (char_i) inside
        CH_BS: begin
          if (col_q != '0) col_d = col_q - 1'b1;
        end
        CH_TAB: begin
          // tab stop past the right edge moves to the next row
          if (col_tab >= COL_END) line_feed = 1'b1;
          else col_d = col_tab[CW-1:0];
        end
        CH_CR: col_d = '0;
        CH_LF: line_feed = 1'b1;
        [CH_SPACE:CH_DEL]: begin
          print_o = 1'b1;
          if (col_inc >= COL_END) line_feed = 1'b1;
          else col_d = col_inc[CW-1:0];
        end
        default: ;
      endcase
    end

    // wrap to the top row instead of scrolling
    if (line_feed) begin
      col_d = '0;
      row_d = (row_inc >= ROW_END) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

[rtl/ttw_checker.sv]
// Port-level assertions for the text terminal writer, bound to the top level.
// Depends on ttw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttw_checker import ttw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  req_type_i,
  input logic        done_o,
  input logic [6:0]  cursor_column_o,
  input logic [4:0]  cursor_row_o
);

  // results never show while the cell sweep runs
  `ASSERT_NOW(a_done_not_busy, done_o, !busy_o)

  // every beat other than clear answers on the next cycle
  `ASSERT_NEXT(a_quick_result, start_i && !busy_o && (req_type_i != REQ_CLEAR), done_o)

  // clear starts the sweep at once
  `ASSERT_NEXT(a_clear_busy, start_i && !busy_o && (req_type_i == REQ_CLEAR), busy_o && !done_o)

  // cursor moves only on an accepted beat
  `ASSERT_NEXT(a_cursor_hold, !(start_i && !busy_o),
               $stable(cursor_column_o) && $stable(cursor_row_o))

endmodule

bind text_terminal_writer_top ttw_checker u_checker (.*);
